FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker of the DDA line rasterizer.
// Depends on nothing; each macro takes a label, clock, active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/dda_pkg.sv
// Shared types and codes of the DDA line rasterizer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package dda_pkg;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIVIDE
    } ctrl_state_t;

    typedef struct packed {
        logic load_line;
        logic advance_line;
        logic div_run;
    } dda_cmd_t;

    typedef struct packed {
        logic zero_step;
        logic line_active;
        logic div_done;
        logic out_free;
    } dda_status_t;

endpackage

FILE: hw/rtl/dda_line_if.sv
// Channel that carries line commands: start with endpoints, or step.
// Depends on nothing; the coordinate width is a parameter.
`timescale 1ns / 1ps

interface dda_line_if #(
    parameter int COORD_WIDTH = 10
);
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [COORD_WIDTH-1:0] start_x;
    logic [COORD_WIDTH-1:0] start_y;
    logic [COORD_WIDTH-1:0] end_x;
    logic [COORD_WIDTH-1:0] end_y;

    modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

FILE: hw/rtl/dda_pixel_if.sv
// Channel that carries plotted pixels of the DDA line rasterizer.
// Depends on nothing; the coordinate width is a parameter.
`timescale 1ns / 1ps

interface dda_pixel_if #(
    parameter int COORD_WIDTH = 10
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic                   last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

FILE: hw/rtl/dda_ctrl.sv
// Controller of the DDA line rasterizer: accepts items and sequences the divider.
// Depends on dda_pkg for the state type, action codes and command/status structs.
`timescale 1ns / 1ps

module dda_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_action,
    input  dda_pkg::dda_status_t status,
    output dda_pkg::dda_cmd_t    cmd,
    output logic                 in_ready
);

    dda_pkg::ctrl_state_t state_reg;
    dda_pkg::ctrl_state_t state_next;
    logic                 in_fire;

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dda_pkg::ST_IDLE:
            begin
                if (cmd.load_line && !status.zero_step)
                begin
                    state_next = dda_pkg::ST_DIVIDE;
                end
            end
            dda_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = dda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        cmd.load_line    = 1'b0;
        cmd.advance_line = 1'b0;
        cmd.div_run      = 1'b0;
        unique case (state_reg)
            dda_pkg::ST_IDLE:
            begin
                in_ready         = status.out_free;
                cmd.load_line    = in_fire && (in_action == dda_pkg::ACT_START);
                cmd.advance_line = in_fire && (in_action == dda_pkg::ACT_STEP)
                                   && status.line_active;
            end
            dda_pkg::ST_DIVIDE:
            begin
                cmd.div_run = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/dda_datapath.sv
// Datapath of the DDA line rasterizer: accumulators, serial divider and output register.
// Depends on dda_pkg for the command and status structs.
`timescale 1ns / 1ps

module dda_datapath #(
    parameter int COORD_WIDTH = 10,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [COORD_WIDTH-1:0] start_x,
    input  logic [COORD_WIDTH-1:0] start_y,
    input  logic [COORD_WIDTH-1:0] end_x,
    input  logic [COORD_WIDTH-1:0] end_y,
    input  dda_pkg::dda_cmd_t      cmd,
    output dda_pkg::dda_status_t   status,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [COORD_WIDTH-1:0] pixel_x,
    output logic [COORD_WIDTH-1:0] pixel_y,
    output logic                   last_pixel
);

    localparam int POS_W  = COORD_WIDTH + FRAC_BITS + 1;
    localparam int INC_W  = FRAC_BITS + 2;
    localparam int LEFT_W = COORD_WIDTH + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int R_W    = COORD_WIDTH + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 2);

    logic [POS_W-1:0]       xpos_reg;
    logic [POS_W-1:0]       ypos_reg;
    logic [INC_W-1:0]       xinc_reg;
    logic [INC_W-1:0]       yinc_reg;
    logic [LEFT_W-1:0]      left_reg;
    logic                   active_reg;
    logic [COORD_WIDTH-1:0] step_reg;
    logic [R_W-1:0]         xrem_reg;
    logic [R_W-1:0]         yrem_reg;
    logic [Q_W-1:0]         xq_reg;
    logic [Q_W-1:0]         yq_reg;
    logic                   xneg_reg;
    logic                   yneg_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   out_valid_reg;
    logic [COORD_WIDTH-1:0] out_x_reg;
    logic [COORD_WIDTH-1:0] out_y_reg;
    logic                   out_last_reg;

    logic [COORD_WIDTH-1:0] adx;
    logic [COORD_WIDTH-1:0] ady;
    logic [COORD_WIDTH-1:0] step;
    logic [R_W-1:0]         xtrial;
    logic [R_W-1:0]         ytrial;
    logic                   xge;
    logic                   yge;
    logic [R_W-1:0]         xrem_next;
    logic [R_W-1:0]         yrem_next;
    logic [Q_W-1:0]         xq_next;
    logic [Q_W-1:0]         yq_next;
    logic [INC_W-1:0]       xinc_next;
    logic [INC_W-1:0]       yinc_next;
    logic [POS_W-1:0]       xpos_next;
    logic [POS_W-1:0]       ypos_next;
    logic [LEFT_W-1:0]      left_next;
    logic                   div_last;

    assign adx  = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
    assign ady  = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
    assign step = (adx >= ady) ? adx : ady;

    // The first quotient bit compares the magnitude itself; later bits use the doubled remainder.
    assign xtrial    = (cnt_reg == '0) ? xrem_reg : {xrem_reg[R_W-2:0], 1'b0};
    assign ytrial    = (cnt_reg == '0) ? yrem_reg : {yrem_reg[R_W-2:0], 1'b0};
    assign xge       = xtrial >= {1'b0, step_reg};
    assign yge       = ytrial >= {1'b0, step_reg};
    assign xrem_next = xge ? (xtrial - {1'b0, step_reg}) : xtrial;
    assign yrem_next = yge ? (ytrial - {1'b0, step_reg}) : ytrial;
    assign xq_next   = {xq_reg[Q_W-2:0], xge};
    assign yq_next   = {yq_reg[Q_W-2:0], yge};
    assign xinc_next = xneg_reg ? (INC_W'(0) - {1'b0, xq_next}) : {1'b0, xq_next};
    assign yinc_next = yneg_reg ? (INC_W'(0) - {1'b0, yq_next}) : {1'b0, yq_next};
    assign div_last  = cnt_reg == CNT_W'(FRAC_BITS);

    assign xpos_next = xpos_reg + {{(POS_W-INC_W){xinc_reg[INC_W-1]}}, xinc_reg};
    assign ypos_next = ypos_reg + {{(POS_W-INC_W){yinc_reg[INC_W-1]}}, yinc_reg};
    assign left_next = left_reg - LEFT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cmd.load_line)
            begin
                active_reg <= step != '0;
                cnt_reg    <= '0;
            end
            else if (cmd.advance_line)
            begin
                active_reg <= left_next != '0;
            end
            else if (cmd.div_run)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.load_line || cmd.advance_line)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_line)
        begin
            xpos_reg     <= {1'b0, start_x, FRAC_BITS'(0)};
            ypos_reg     <= {1'b0, start_y, FRAC_BITS'(0)};
            xinc_reg     <= '0;
            yinc_reg     <= '0;
            left_reg     <= {1'b0, step};
            step_reg     <= step;
            xrem_reg     <= {1'b0, adx};
            yrem_reg     <= {1'b0, ady};
            xq_reg       <= '0;
            yq_reg       <= '0;
            xneg_reg     <= end_x < start_x;
            yneg_reg     <= end_y < start_y;
            out_x_reg    <= start_x;
            out_y_reg    <= start_y;
            out_last_reg <= step == '0;
        end
        else if (cmd.advance_line)
        begin
            xpos_reg     <= xpos_next;
            ypos_reg     <= ypos_next;
            left_reg     <= left_next;
            out_x_reg    <= xpos_next[FRAC_BITS +: COORD_WIDTH];
            out_y_reg    <= ypos_next[FRAC_BITS +: COORD_WIDTH];
            out_last_reg <= left_next == '0;
        end
        else if (cmd.div_run)
        begin
            xrem_reg <= xrem_next;
            yrem_reg <= yrem_next;
            xq_reg   <= xq_next;
            yq_reg   <= yq_next;
            if (div_last)
            begin
                xinc_reg <= xinc_next;
                yinc_reg <= yinc_next;
            end
        end
    end

    assign status.zero_step   = step == '0;
    assign status.line_active = active_reg;
    assign status.div_done    = cmd.div_run && div_last;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign pixel_x    = out_x_reg;
    assign pixel_y    = out_y_reg;
    assign last_pixel = out_last_reg;

endmodule

FILE: hw/rtl/dda_line_rasterizer_top.sv
// Top level of the DDA line rasterizer: joins the controller and the datapath.
// Depends on dda_pkg, dda_line_if, dda_pixel_if, dda_ctrl and dda_datapath.
//
//   channel | direction | item
//   line    | in        | action, start_x, start_y, end_x, end_y
//   pixel   | out       | pixel_x, pixel_y, last_pixel
//
// A step item on an active line puts its pixel in the output register on the next cycle;
// with no line active it yields no pixel. A start item puts its first pixel out on the
// next cycle; if the endpoints differ, the serial divider then runs with line.ready low.
// Input is taken only while the output register is empty or being drained this cycle.
// Reset is asynchronous and active low; it clears the controller, the valid flag and the line.
`timescale 1ns / 1ps

module dda_line_rasterizer_top #(
    parameter int COORD_WIDTH = 10,
    parameter int FRAC_BITS   = 16
) (
    input logic        clk,
    input logic        rst_n,
    dda_line_if.sink   line,
    dda_pixel_if.source pixel
);

    dda_pkg::dda_cmd_t    cmd;
    dda_pkg::dda_status_t status;

    dda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (line.valid),
        .in_action (line.action),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (line.ready)
    );

    dda_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_x    (line.start_x),
        .start_y    (line.start_y),
        .end_x      (line.end_x),
        .end_y      (line.end_y),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (pixel.ready),
        .out_valid  (pixel.valid),
        .pixel_x    (pixel.pixel_x),
        .pixel_y    (pixel.pixel_y),
        .last_pixel (pixel.last_pixel)
    );

endmodule

FILE: hw/rtl/dda_checker.sv
// Port-level checks of the DDA line rasterizer, bound to the top level.
// Depends on assert_macros.svh, on dda_pkg for the action codes and on the top level's ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dda_checker #(
    parameter int COORD_WIDTH = 10
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_action,
    input logic [COORD_WIDTH-1:0] start_x,
    input logic [COORD_WIDTH-1:0] start_y,
    input logic [COORD_WIDTH-1:0] end_x,
    input logic [COORD_WIDTH-1:0] end_y,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [COORD_WIDTH-1:0] pixel_x,
    input logic [COORD_WIDTH-1:0] pixel_y,
    input logic                   last_pixel
);

    logic start_fire;
    logic same_ends;

    assign start_fire = in_valid && in_ready && (in_action == dda_pkg::ACT_START);
    assign same_ends  = (start_x == end_x) && (start_y == end_y);

    // A pending pixel stays offered until it is taken.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A start item shows its start pixel next cycle, flagged last only for equal endpoints.
    `ASSERT_NEXT(a_start_pixel, clk, rst_n, start_fire,
        out_valid && (pixel_x == $past(start_x)) && (pixel_y == $past(start_y))
        && (last_pixel == $past(same_ends)))

    // While the output register is stalled, no new item is taken.
    `ASSERT_SAME(a_no_take_on_stall, clk, rst_n, out_valid && !out_ready, !in_ready)

    // A real line keeps the input closed while its increments are divided.
    `ASSERT_NEXT(a_divide_busy, clk, rst_n, start_fire && !same_ends, !in_ready)

endmodule

bind dda_line_rasterizer_top dda_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_dda_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (line.valid),
    .in_ready   (line.ready),
    .in_action  (line.action),
    .start_x    (line.start_x),
    .start_y    (line.start_y),
    .end_x      (line.end_x),
    .end_y      (line.end_y),
    .out_valid  (pixel.valid),
    .out_ready  (pixel.ready),
    .pixel_x    (pixel.pixel_x),
    .pixel_y    (pixel.pixel_y),
    .last_pixel (pixel.last_pixel)
);

FILE: dv/dda_line_rasterizer_top_tb.sv
// Self-checking testbench for dda_line_rasterizer_top: drives line commands, predicts every pixel.
// Depends on dda_pkg, dda_line_if, dda_pixel_if and the rasterizer RTL under hw/rtl.
`timescale 1ns / 1ps

module dda_line_rasterizer_top_tb;

    localparam int COORD_W = 10;
    localparam int FRAC_W = 16;
    localparam int POS_W = COORD_W + FRAC_W + 1;
    localparam int INC_W = FRAC_W + 2;
    localparam int LEFT_W = COORD_W + 1;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_AT_CYCLE = 400;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 3 * (FRAC_W + 1);

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } line_cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dda_line_if #(.COORD_WIDTH(COORD_W)) line_bus ();
    dda_pixel_if #(.COORD_WIDTH(COORD_W)) pixel_bus ();

    dda_line_rasterizer_top #(
        .COORD_WIDTH(COORD_W),
        .FRAC_BITS(FRAC_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .line(line_bus),
        .pixel(pixel_bus)
    );

    always #1 clk = ~clk;

    logic      send_valid = 1'b0;
    line_cmd_t send_cmd = '0;
    logic      rx_ready = 1'b0;

    assign line_bus.valid = send_valid;
    assign line_bus.action = send_cmd.action;
    assign line_bus.start_x = send_cmd.sx;
    assign line_bus.start_y = send_cmd.sy;
    assign line_bus.end_x = send_cmd.ex;
    assign line_bus.end_y = send_cmd.ey;
    assign pixel_bus.ready = rx_ready;

    line_cmd_t pending_cmds[$];
    pixel_t    pixels_due[$];

    logic [POS_W-1:0]  x_pos = '0;
    logic [POS_W-1:0]  y_pos = '0;
    logic [INC_W-1:0]  x_inc = '0;
    logic [INC_W-1:0]  y_inc = '0;
    logic [LEFT_W-1:0] steps_left = '0;
    logic              drawing = 1'b0;

    int error_count = 0;
    int start_count = 0;
    int dot_count = 0;
    int step_count = 0;
    int idle_step_count = 0;
    int lines_finished = 0;
    int pixels_checked = 0;

    function automatic logic [INC_W-1:0] increment_of(input logic [COORD_W-1:0] from_c,
                                                      input logic [COORD_W-1:0] to_c,
                                                      input logic [LEFT_W-1:0] span);
        logic [COORD_W-1:0]        mag;
        logic [COORD_W+FRAC_W-1:0] num;
        logic [INC_W-1:0]          quo;
        if (span == 0)
        begin
            return '0;
        end
        mag = (to_c >= from_c) ? to_c - from_c : from_c - to_c;
        num = {mag, {FRAC_W{1'b0}}};
        quo = INC_W'(num / span);
        if (to_c < from_c)
        begin
            quo = -quo;
        end
        return quo;
    endfunction

    function automatic pixel_t pixel_at(input logic last);
        pixel_t px;
        px.x = x_pos[FRAC_W +: COORD_W];
        px.y = y_pos[FRAC_W +: COORD_W];
        px.last = last;
        return px;
    endfunction

    // Updates the line state for one accepted item and queues the pixel it produces.
    task automatic trace_line_item(input line_cmd_t cmd);
        logic [COORD_W-1:0] adx;
        logic [COORD_W-1:0] ady;
        logic [LEFT_W-1:0]  span;
        if (cmd.action == dda_pkg::ACT_START)
        begin
            adx = (cmd.ex >= cmd.sx) ? cmd.ex - cmd.sx : cmd.sx - cmd.ex;
            ady = (cmd.ey >= cmd.sy) ? cmd.ey - cmd.sy : cmd.sy - cmd.ey;
            span = LEFT_W'((adx >= ady) ? adx : ady);
            x_inc = increment_of(cmd.sx, cmd.ex, span);
            y_inc = increment_of(cmd.sy, cmd.ey, span);
            x_pos = {1'b0, cmd.sx, {FRAC_W{1'b0}}};
            y_pos = {1'b0, cmd.sy, {FRAC_W{1'b0}}};
            steps_left = span;
            drawing = (span != 0);
            start_count++;
            if (span == 0)
            begin
                dot_count++;
            end
            pixels_due.push_back(pixel_at(span == 0));
            return;
        end
        step_count++;
        if (!drawing)
        begin
            idle_step_count++;
            return;
        end
        x_pos = x_pos + {{(POS_W-INC_W){x_inc[INC_W-1]}}, x_inc};
        y_pos = y_pos + {{(POS_W-INC_W){y_inc[INC_W-1]}}, y_inc};
        steps_left = steps_left - LEFT_W'(1);
        if (steps_left == 0)
        begin
            drawing = 1'b0;
            lines_finished++;
        end
        pixels_due.push_back(pixel_at(steps_left == 0));
    endtask

    task automatic add_start(input int sx, input int sy, input int ex, input int ey);
        line_cmd_t cmd;
        cmd.action = dda_pkg::ACT_START;
        cmd.sx = sx[COORD_W-1:0];
        cmd.sy = sy[COORD_W-1:0];
        cmd.ex = ex[COORD_W-1:0];
        cmd.ey = ey[COORD_W-1:0];
        pending_cmds.push_back(cmd);
    endtask

    task automatic add_steps(input int count);
        line_cmd_t cmd;
        repeat (count)
        begin
            cmd.action = dda_pkg::ACT_STEP;
            cmd.sx = COORD_W'($urandom_range(0, COORD_MAX));
            cmd.sy = COORD_W'($urandom_range(0, COORD_MAX));
            cmd.ex = COORD_W'($urandom_range(0, COORD_MAX));
            cmd.ey = COORD_W'($urandom_range(0, COORD_MAX));
            pending_cmds.push_back(cmd);
        end
    endtask

    function automatic int near(input int base, input int reach);
        int v;
        v = base + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
        end
        return v;
    endfunction

    int gap_left = 0;
    int burst_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
        end
        else
        begin
            if (send_valid && line_bus.ready)
            begin
                trace_line_item(send_cmd);
            end
            if (!send_valid || line_bus.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    send_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    send_cmd <= pending_cmds.pop_front();
                    send_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    send_valid <= 1'b0;
                end
            end
        end
    end

    int rx_cycles = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ready <= 1'b0;
        end
        else
        begin
            rx_cycles <= rx_cycles + 1;
            if (rx_cycles == HOLD_AT_CYCLE)
            begin
                hold_left <= HOLD_CYCLES;
                rx_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rx_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 2);
                    mode_left <= $urandom_range(8, 64);
                end
                else
                begin
                    mode_left <= mode_left - 1;
                end
                unique case (stall_mode)
                    0: rx_ready <= 1'b1;
                    1: rx_ready <= ($urandom_range(0, 3) != 0);
                    default: rx_ready <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pixel_bus.valid && rx_ready)
        begin
            if (pixels_due.size() == 0)
            begin
                error_count++;
                $display("%0t: pixel expected none actual x=%0d y=%0d last=%0d", $time,
                         pixel_bus.pixel_x, pixel_bus.pixel_y, pixel_bus.last_pixel);
            end
            else
            begin
                want = pixels_due.pop_front();
                pixels_checked++;
                if (pixel_bus.pixel_x !== want.x)
                begin
                    error_count++;
                    $display("%0t: pixel_x expected %0d actual %0d", $time,
                             want.x, pixel_bus.pixel_x);
                end
                if (pixel_bus.pixel_y !== want.y)
                begin
                    error_count++;
                    $display("%0t: pixel_y expected %0d actual %0d", $time,
                             want.y, pixel_bus.pixel_y);
                end
                if (pixel_bus.last_pixel !== want.last)
                begin
                    error_count++;
                    $display("%0t: last_pixel expected %0d actual %0d", $time,
                             want.last, pixel_bus.last_pixel);
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("dda_line_rasterizer_top_tb: errors");
        $finish;
    end

    initial
    begin
        int counted;
        int kind;
        int sx;
        int sy;
        int ex;
        int ey;
        int reach;
        int len;
        int plan;
        int n;

        add_steps(1);
        add_start(5, 5, 5, 5);
        add_steps(1);
        add_start(0, 0, COORD_MAX, COORD_MAX);
        add_steps(3);
        add_start(COORD_MAX, COORD_MAX, 0, 0);
        add_steps(2);
        add_start(0, COORD_MAX, COORD_MAX, 0);
        add_steps(1);
        add_start(10, 20, 13, 12);
        add_steps(9);
        add_start(0, 0, 1, 0);
        add_steps(1);
        add_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                add_steps(1);
            end
            else if (kind == 1)
            begin
                sx = $urandom_range(0, COORD_MAX);
                sy = $urandom_range(0, COORD_MAX);
                add_start(sx, sy, sx, sy);
                counted++;
            end
            else
            begin
                sx = $urandom_range(0, COORD_MAX);
                sy = $urandom_range(0, COORD_MAX);
                reach = $urandom_range(0, 19);
                reach = (reach == 0) ? COORD_MAX : ((reach < 4) ? 200 : 16);
                ex = near(sx, reach);
                ey = near(sy, reach);
                add_start(sx, sy, ex, ey);
                counted++;
                len = (ex >= sx) ? ex - sx : sx - ex;
                n = (ey >= sy) ? ey - sy : sy - ey;
                len = (n > len) ? n : len;
                plan = $urandom_range(0, 19);
                if (len > 250)
                begin
                    n = $urandom_range(0, 30);
                end
                else if (plan < 14)
                begin
                    n = len;
                end
                else if (plan < 17)
                begin
                    n = $urandom_range(0, len);
                end
                else
                begin
                    n = len + $urandom_range(1, 3);
                end
                add_steps(n);
                counted += (n < len) ? n : len;
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || send_valid)
        begin
            @(negedge clk);
        end
        while (pixels_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d line starts (%0d with equal endpoints) and %0d step items,",
                 start_count, dot_count, step_count);
        $display("%0d of them with no line active; %0d lines ran out, %0d pixels compared.",
                 idle_step_count, lines_finished, pixels_checked);
        if (error_count == 0)
        begin
            $display("dda_line_rasterizer_top_tb: clean");
        end
        else
        begin
            $display("dda_line_rasterizer_top_tb: errors");
        end
        $finish;
    end

endmodule
